// ===== rtl/rpsd_pkg.sv =====
// ============================================================================
// rpsd_pkg
// Shared codes and types for the relay pulse scan driver.
// ============================================================================
`default_nettype none

package rpsd_pkg;

   // Relay mode codes
   localparam logic [1:0] MODE_OFF       = 2'd0;
   localparam logic [1:0] MODE_ON        = 2'd1;
   localparam logic [1:0] MODE_PULSE_ON  = 2'd2;
   localparam logic [1:0] MODE_PULSE_OFF = 2'd3;

   // Command codes
   localparam logic OP_SET      = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // Control register indexes
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PULSE_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OPEN_DRAIN_COUNT  = 2'd1;

   // Control register widths and reset values
   localparam int unsigned HALF_PERIOD_BITS = 32;
   localparam int unsigned OD_COUNT_BITS    = 4;
   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 32'd48000000;
   localparam logic [OD_COUNT_BITS-1:0]    OD_COUNT_RESET    = 4'd4;

   // Pin drive word for one serviced relay
   typedef struct packed {
      logic pin_written;
      logic pin_level;
      logic enable_used;
      logic output_enable;
   } drive_type;

endpackage

`default_nettype wire

// ===== rtl/rpsd_drive.sv =====
// ============================================================================
// rpsd_drive
// Dispatch evaluation for one relay: pulse timing check, mode toggle and
// pin drive encoding (push-pull or inverted open-drain).
// ============================================================================
`default_nettype none

module rpsd_drive
   import rpsd_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32,
   parameter int unsigned IDX_W     = 4
) (
   input  wire logic [1:0]                  cur_mode,
   input  wire logic [TIME_BITS-1:0]        cur_stamp,
   input  wire logic [TIME_BITS-1:0]        now,
   input  wire logic [IDX_W-1:0]            relay,
   input  wire logic [HALF_PERIOD_BITS-1:0] half_period,
   input  wire logic [OD_COUNT_BITS-1:0]    od_count,
   output      logic [1:0]                  next_mode,
   output      logic                        toggle,
   output      drive_type                   drive
);

   localparam int unsigned CMP_W = (TIME_BITS > HALF_PERIOD_BITS) ? TIME_BITS
                                                                  : HALF_PERIOD_BITS;
   localparam int unsigned NUM_W = (IDX_W > OD_COUNT_BITS) ? IDX_W : OD_COUNT_BITS;

   logic [TIME_BITS-1:0] elapsed;
   logic                 period_over;
   logic                 open_drain;
   logic                 drive_on;
   logic                 drive_any;

   // Elapsed time wraps with the time counter
   assign elapsed     = now - cur_stamp;
   assign period_over = CMP_W'(elapsed) >= CMP_W'(half_period);
   assign open_drain  = NUM_W'(relay) < NUM_W'(od_count);

   // Decide the level to drive and the mode that follows
   always_comb begin
      next_mode = cur_mode;
      toggle    = 1'b0;
      drive_on  = 1'b0;
      drive_any = 1'b0;
      unique case (cur_mode)
         MODE_OFF: begin
            drive_any = 1'b1;
         end
         MODE_ON: begin
            drive_any = 1'b1;
            drive_on  = 1'b1;
         end
         MODE_PULSE_ON: begin
            if (period_over) begin
               toggle    = 1'b1;
               drive_any = 1'b1;
               next_mode = MODE_PULSE_OFF;
            end
         end
         MODE_PULSE_OFF: begin
            if (period_over) begin
               toggle    = 1'b1;
               drive_any = 1'b1;
               drive_on  = 1'b1;
               next_mode = MODE_PULSE_ON;
            end
         end
         default: begin
            next_mode = cur_mode;
         end
      endcase
   end

   // Encode the pin word; open-drain relays are active low with enable
   always_comb begin
      drive.pin_written   = drive_any;
      drive.pin_level     = drive_any & (open_drain ? ~drive_on : drive_on);
      drive.enable_used   = drive_any & open_drain;
      drive.output_enable = drive_any & open_drain & drive_on;
   end

endmodule

`default_nettype wire

// ===== rtl/relay_pulse_scan_driver.sv =====
// ============================================================================
// relay_pulse_scan_driver
// Per-relay mode and time stamp store with a round-robin dispatch that
// services one relay per dispatch command, driving its pin when due.
// ============================================================================
// Usage:
//   Command channel: pulse start with req_* valid while busy is low. A set
//   command (req_operation 0) stores req_new_mode and req_now as the stamp
//   for req_relay_index when the mode changes; indexes at or above
//   RELAY_COUNT are dropped. A dispatch (req_operation 1) advances the
//   service pointer and services that relay, driving its pin when due.
//   Result channel: one word per dispatch, shown for one cycle with rsp_strobe
//   starting at the edge after the command edge. Set commands give none.
//   The receiver cannot stall; every word must be taken when strobed.
//   A new command is taken only while busy is low. The state memory is read
//   in the accept cycle and written back in the next one, with busy high
//   meanwhile, so accesses never overlap.
//   CSR channel: csr_ready is always high; write registers while idle.
//   Reset: synchronous, clears the service pointer, the per-relay valid
//   bits (unwritten relays read as off with stamp zero) and loads the CSR
//   reset values. No clearing pass is needed.
// ============================================================================
`default_nettype none

module relay_pulse_scan_driver
   import rpsd_pkg::*;
#(
   parameter int unsigned RELAY_COUNT = 11,
   parameter int unsigned TIME_BITS   = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // command channel
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic                        req_operation,
   input  wire logic [3:0]                  req_relay_index,
   input  wire logic [1:0]                  req_new_mode,
   input  wire logic [31:0]                 req_now,
   // result channel
   output      logic                        rsp_strobe,
   output      logic [3:0]                  rsp_relay_number,
   output      logic                        rsp_pin_written,
   output      logic                        rsp_pin_level,
   output      logic                        rsp_enable_used,
   output      logic                        rsp_output_enable,
   output      logic [1:0]                  rsp_mode_now,
   // control registers
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [HALF_PERIOD_BITS-1:0] csr_data
);

   localparam int unsigned IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
   localparam int unsigned CNT_W = (IDX_W > 4) ? IDX_W + 1 : 5;
   localparam logic [IDX_W-1:0] LAST_RELAY = IDX_W'(RELAY_COUNT - 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   // State memory
   logic [1:0]           mode_mem  [RELAY_COUNT];
   logic [TIME_BITS-1:0] stamp_mem [RELAY_COUNT];

   // Control state
   logic                        state_ff, state_in;
   logic [IDX_W-1:0]            ptr_ff, ptr_in;
   logic [RELAY_COUNT-1:0]      valid_ff, valid_in;
   logic [HALF_PERIOD_BITS-1:0] half_period_ff, half_period_in;
   logic [OD_COUNT_BITS-1:0]    od_count_ff, od_count_in;
   logic                        strobe_ff, strobe_in;

   // Command and read-data registers
   logic                 op_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     addr_ff;
   logic [1:0]           new_mode_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [1:0]           rd_mode_ff;
   logic [TIME_BITS-1:0] rd_stamp_ff;
   logic                 rd_valid_ff;

   // Result registers
   logic [3:0] number_ff;
   drive_type  drive_ff;
   logic [1:0] mode_now_ff;

   logic                 accept;
   logic                 set_in_range;
   logic [IDX_W-1:0]     ptr_next;
   logic [IDX_W-1:0]     rd_addr;
   logic [1:0]           cur_mode;
   logic [TIME_BITS-1:0] cur_stamp;
   logic [1:0]           next_mode;
   logic                 toggle;
   drive_type            drive;
   logic                 wr_en;
   logic [1:0]           wr_mode;

   assign busy       = (state_ff == S_EXEC);
   assign accept     = start & ~busy;
   assign csr_ready  = 1'b1;

   // Pick the entry to read: set target or next relay in the scan
   assign set_in_range = CNT_W'(req_relay_index) < CNT_W'(RELAY_COUNT);
   assign ptr_next     = (ptr_ff == LAST_RELAY) ? '0 : ptr_ff + 1'b1;
   always_comb begin
      priority if (req_operation == OP_DISPATCH) begin
         rd_addr = ptr_next;
      end else if (set_in_range) begin
         rd_addr = IDX_W'(req_relay_index);
      end else begin
         rd_addr = '0;
      end
   end

   // Read the entry at the accept edge
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_mode_ff  <= mode_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         op_ff       <= req_operation;
         hit_ff      <= set_in_range;
         addr_ff     <= rd_addr;
         new_mode_ff <= req_new_mode;
         now_ff      <= TIME_BITS'(req_now);
      end
   end

   // Unwritten entries read as off with stamp zero
   assign cur_mode  = rd_valid_ff ? rd_mode_ff  : MODE_OFF;
   assign cur_stamp = rd_valid_ff ? rd_stamp_ff : '0;

   rpsd_drive #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W)
   ) u_drive (
      .cur_mode    (cur_mode),
      .cur_stamp   (cur_stamp),
      .now         (now_ff),
      .relay       (addr_ff),
      .half_period (half_period_ff),
      .od_count    (od_count_ff),
      .next_mode   (next_mode),
      .toggle      (toggle),
      .drive       (drive)
   );

   // Decide the write-back
   always_comb begin
      if (op_ff == OP_DISPATCH) begin
         wr_en   = busy & toggle;
         wr_mode = next_mode;
      end else begin
         wr_en   = busy & hit_ff & (cur_mode != new_mode_ff);
         wr_mode = new_mode_ff;
      end
   end

   // Write back modified entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mode_mem[addr_ff]  <= wr_mode;
         stamp_mem[addr_ff] <= now_ff;
      end
   end

   // Next-state logic for control registers
   always_comb begin
      state_in       = accept ? S_EXEC : S_IDLE;
      ptr_in         = (accept && req_operation == OP_DISPATCH) ? ptr_next : ptr_ff;
      valid_in       = valid_ff;
      if (wr_en) begin
         valid_in[addr_ff] = 1'b1;
      end
      strobe_in      = busy & (op_ff == OP_DISPATCH);
      half_period_in = half_period_ff;
      od_count_in    = od_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PULSE_HALF_PERIOD: half_period_in = csr_data;
            REG_OPEN_DRAIN_COUNT:  od_count_in    = csr_data[OD_COUNT_BITS-1:0];
            default: begin
               half_period_in = half_period_ff;
            end
         endcase
      end
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ptr_ff         <= '0;
         valid_ff       <= '0;
         strobe_ff      <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
         od_count_ff    <= OD_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         valid_ff       <= valid_in;
         strobe_ff      <= strobe_in;
         half_period_ff <= half_period_in;
         od_count_ff    <= od_count_in;
      end
   end

   // Register the result word
   always_ff @(posedge clock) begin
      if (busy) begin
         number_ff   <= 4'(addr_ff);
         drive_ff    <= drive;
         mode_now_ff <= next_mode;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_relay_number  = number_ff;
   assign rsp_pin_written   = drive_ff.pin_written;
   assign rsp_pin_level     = drive_ff.pin_level;
   assign rsp_enable_used   = drive_ff.enable_used;
   assign rsp_output_enable = drive_ff.output_enable;
   assign rsp_mode_now      = mode_now_ff;

endmodule

`default_nettype wire
